// File: sv/pidc_pkg.sv
// shared widths, register indexes, codes and pipeline types of the pid step core
package pidc_pkg;

    localparam int DATA_W   = 16;
    localparam int ERR_W    = 17;
    localparam int PREV_W   = 18;
    localparam int SUM_W    = 32;
    localparam int DIFF_W   = 18;
    localparam int PROD_P_W = DATA_W + ERR_W;
    localparam int PROD_I_W = DATA_W + SUM_W;
    localparam int PROD_D_W = DATA_W + DIFF_W;
    localparam int ACC_W    = 50;
    localparam int FRAC_W   = 8;
    localparam int SCALED_W = ACC_W - FRAC_W;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [DATA_W-1:0] DRIVE_MIN_RST = -16'sd127;
    localparam logic signed [DATA_W-1:0] DRIVE_MAX_RST = 16'sd127;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_DRIVE_MIN   = 3'd3,
        REG_DRIVE_MAX   = 3'd4,
        REG_SETTLE_BAND = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic signed [DATA_W-1:0] drive_min;
        logic signed [DATA_W-1:0] drive_max;
        logic        [DATA_W-1:0] settle_band;
    } cfg_t;

    // loop terms after the state update
    typedef struct packed {
        logic                     clear;
        logic                     reached;
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  integ;
        logic signed [DIFF_W-1:0] diff;
    } term_t;

    // registered products
    typedef struct packed {
        logic                       clear;
        logic                       reached;
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
    } prod_t;

endpackage

// File: sv/pidc_cfg_regs.sv
// configuration register file of the pid step core
module pidc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidc_pkg::DATA_W-1:0]         cfg_data,
    output pidc_pkg::cfg_t                      cfg
);

    pidc_pkg::cfg_t cfg_reg;
    pidc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (pidc_pkg::cfg_reg_t'(cfg_index))
                pidc_pkg::REG_GAIN_P:      cfg_next.gain_p      = $signed(cfg_data);
                pidc_pkg::REG_GAIN_I:      cfg_next.gain_i      = $signed(cfg_data);
                pidc_pkg::REG_GAIN_D:      cfg_next.gain_d      = $signed(cfg_data);
                pidc_pkg::REG_DRIVE_MIN:   cfg_next.drive_min   = $signed(cfg_data);
                pidc_pkg::REG_DRIVE_MAX:   cfg_next.drive_max   = $signed(cfg_data);
                pidc_pkg::REG_SETTLE_BAND: cfg_next.settle_band = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p      <= '0;
            cfg_reg.gain_i      <= '0;
            cfg_reg.gain_d      <= '0;
            cfg_reg.drive_min   <= pidc_pkg::DRIVE_MIN_RST;
            cfg_reg.drive_max   <= pidc_pkg::DRIVE_MAX_RST;
            cfg_reg.settle_band <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/pidc_drive_calc.sv
// sum of products, scaling by the q8.8 gain point and clamping of the drive
module pidc_drive_calc (
    input  pidc_pkg::prod_t                     prod,
    input  logic signed [pidc_pkg::DATA_W-1:0]  drive_min,
    input  logic signed [pidc_pkg::DATA_W-1:0]  drive_max,
    output logic signed [pidc_pkg::DATA_W-1:0]  drive,
    output logic                                saturated,
    output logic                                target_reached
);

    logic signed [pidc_pkg::ACC_W-1:0]    acc;
    logic signed [pidc_pkg::SCALED_W-1:0] scaled;
    logic signed [pidc_pkg::SCALED_W-1:0] lim_hi;
    logic signed [pidc_pkg::SCALED_W-1:0] lim_lo;

    always_comb
    begin
        acc = pidc_pkg::ACC_W'($signed(prod.prod_p))
            + pidc_pkg::ACC_W'($signed(prod.prod_i))
            + pidc_pkg::ACC_W'($signed(prod.prod_d));
        // floor division by 256: drop the fraction bits
        scaled = $signed(acc[pidc_pkg::ACC_W-1:pidc_pkg::FRAC_W]);
        lim_hi = pidc_pkg::SCALED_W'(drive_max);
        lim_lo = pidc_pkg::SCALED_W'(drive_min);

        // upper limit wins when the limits cross
        if (prod.clear)
        begin
            drive     = '0;
            saturated = 1'b0;
        end
        else if (scaled > lim_hi)
        begin
            drive     = drive_max;
            saturated = 1'b1;
        end
        else if (scaled < lim_lo)
        begin
            drive     = drive_min;
            saturated = 1'b1;
        end
        else
        begin
            drive     = $signed(scaled[pidc_pkg::DATA_W-1:0]);
            saturated = 1'b0;
        end
        target_reached = prod.reached && !prod.clear;
    end

endmodule

// File: sv/pid_controller_step_core.sv
// top level of the pid step core: loop state, product pipeline and result register
//
// usage
//   configuration: cfg_write with cfg_index and cfg_data writes one register
//     (gains p/i/d, drive limits, settle band); only while no transaction is in flight
//   input channel: in_valid/in_stall; a transaction carries cmd, setpoint,
//     measured and error_override; cmd clear zeroes the loop state
//   output channel: out_valid/out_stall; one result transaction (drive,
//     saturated, target_reached) for every input transaction, in order
//   throughput: one transaction per cycle unless the output is stalled with all stages full, set by
//     the error/integral update feeding back into the loop state registers
//   pipeline: stage 1 forms error, saturating integral and derivative and
//     updates the state; stage 2 holds the three gain products; stage 3 is the
//     result register after sum, shift and clamp
//   stall: each stage holds while the next one is full and held, so input is
//     still taken while a result waits, until all three stages are occupied
//   reset: state, pipeline valids and configuration return to defaults
//     (gains 0, limits -127 and 127, settle band 0); no output is pending
module pid_controller_step_core (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_write,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pidc_pkg::DATA_W-1:0]            cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   cmd,
    input  logic signed [pidc_pkg::DATA_W-1:0]     setpoint,
    input  logic signed [pidc_pkg::DATA_W-1:0]     measured,
    input  logic signed [pidc_pkg::ERR_W-1:0]      error_override,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pidc_pkg::DATA_W-1:0]     drive,
    output logic                                   saturated,
    output logic                                   target_reached
);

    pidc_pkg::cfg_t cfg;

    // loop state
    logic signed [pidc_pkg::PREV_W-1:0] prev_err_reg;
    logic signed [pidc_pkg::SUM_W-1:0]  err_sum_reg;
    logic signed [pidc_pkg::PREV_W-1:0] prev_err_next;
    logic signed [pidc_pkg::SUM_W-1:0]  err_sum_next;

    // pipeline stages
    logic            s1_valid_reg;
    logic            s2_valid_reg;
    logic            out_valid_reg;
    pidc_pkg::term_t s1_reg;
    pidc_pkg::term_t s1_next;
    pidc_pkg::prod_t s2_reg;
    pidc_pkg::prod_t s2_next;

    logic signed [pidc_pkg::DATA_W-1:0] drive_reg;
    logic                               saturated_reg;
    logic                               reached_reg;
    logic signed [pidc_pkg::DATA_W-1:0] drive_next;
    logic                               saturated_next;
    logic                               reached_next;

    logic load_out;
    logic load_s2;
    logic load_s1;
    logic in_take;

    // stage 1 working signals
    logic signed [pidc_pkg::ERR_W-1:0]   err_raw;
    logic signed [pidc_pkg::ERR_W-1:0]   err;
    logic signed [pidc_pkg::SUM_W:0]     sum_wide;
    logic signed [pidc_pkg::SUM_W-1:0]   sum_sat;
    logic                                crossed;
    logic        [pidc_pkg::ERR_W-1:0]   err_mag;

    pidc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // a stage loads when empty or when its content moves on
    assign load_out = !out_valid_reg || !out_stall;
    assign load_s2  = !s2_valid_reg || load_out;
    assign load_s1  = !s1_valid_reg || load_s2;
    assign in_stall = !load_s1;
    assign in_take  = in_valid && load_s1;

    // stage 1: error select, saturating integral, sign-change reset, derivative
    always_comb
    begin
        err_raw = $signed({setpoint[pidc_pkg::DATA_W-1], setpoint})
                - $signed({measured[pidc_pkg::DATA_W-1], measured});
        err     = (error_override != '0) ? error_override : err_raw;

        sum_wide = $signed({err_sum_reg[pidc_pkg::SUM_W-1], err_sum_reg})
                 + (pidc_pkg::SUM_W+1)'(err);
        if (sum_wide[pidc_pkg::SUM_W] != sum_wide[pidc_pkg::SUM_W-1])
        begin
            sum_sat = sum_wide[pidc_pkg::SUM_W] ? pidc_pkg::SUM_MIN : pidc_pkg::SUM_MAX;
        end
        else
        begin
            sum_sat = $signed(sum_wide[pidc_pkg::SUM_W-1:0]);
        end

        // error strictly changed sign against the previous one
        crossed = (!err[pidc_pkg::ERR_W-1] && (err != '0)
                       && prev_err_reg[pidc_pkg::PREV_W-1])
               || (err[pidc_pkg::ERR_W-1] && !prev_err_reg[pidc_pkg::PREV_W-1]
                       && (prev_err_reg != '0));

        err_mag = err[pidc_pkg::ERR_W-1] ? (~err + 1'b1) : err;

        s1_next.clear   = (cmd == pidc_pkg::CMD_CLEAR);
        s1_next.err     = err;
        s1_next.integ   = crossed ? '0 : sum_sat;
        s1_next.diff    = pidc_pkg::PREV_W'(err) - prev_err_reg;
        s1_next.reached = (err_mag < {1'b0, cfg.settle_band});

        prev_err_next = prev_err_reg;
        err_sum_next  = err_sum_reg;
        if (in_take)
        begin
            if (cmd == pidc_pkg::CMD_CLEAR)
            begin
                prev_err_next = '0;
                err_sum_next  = '0;
            end
            else
            begin
                prev_err_next = pidc_pkg::PREV_W'(err);
                err_sum_next  = s1_next.integ;
            end
        end
    end

    // stage 2: one multiplier per gain
    always_comb
    begin
        s2_next.clear   = s1_reg.clear;
        s2_next.reached = s1_reg.reached;
        s2_next.prod_p  = pidc_pkg::PROD_P_W'(cfg.gain_p * s1_reg.err);
        s2_next.prod_i  = pidc_pkg::PROD_I_W'(cfg.gain_i * s1_reg.integ);
        s2_next.prod_d  = pidc_pkg::PROD_D_W'(cfg.gain_d * s1_reg.diff);
    end

    // stage 3: sum, scale and clamp
    pidc_drive_calc u_drive_calc (
        .prod           (s2_reg),
        .drive_min      (cfg.drive_min),
        .drive_max      (cfg.drive_max),
        .drive          (drive_next),
        .saturated      (saturated_next),
        .target_reached (reached_next)
    );

    // control state and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg  <= '0;
            err_sum_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_err_reg <= prev_err_next;
            err_sum_reg  <= err_sum_next;
            if (load_s1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (load_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (load_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_reg <= s1_next;
        end
        if (load_s2 && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (load_out && s2_valid_reg)
        begin
            drive_reg     <= drive_next;
            saturated_reg <= saturated_next;
            reached_reg   <= reached_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive          = drive_reg;
    assign saturated      = saturated_reg;
    assign target_reached = reached_reg;

endmodule

// File: sv/pidc_checker.sv
// port-level checker of the pid step core and its bind
module pidc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [pidc_pkg::DATA_W-1:0]  drive,
    input logic                                saturated,
    input logic                                target_reached
);

    logic       in_take;
    logic       out_take;
    logic [1:0] flight_reg;
    logic [1:0] flight_next;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    always_comb
    begin
        flight_next = flight_reg;
        if (in_take && !out_take)
        begin
            flight_next = flight_reg + 2'd1;
        end
        else if (!in_take && out_take)
        begin
            flight_next = flight_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= '0;
        end
        else
        begin
            flight_reg <= flight_next;
        end
    end

    // input is held back only by a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // no result without a transaction in flight
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        (flight_reg == 2'd0) |-> !out_valid)
        else $error("result shown with nothing in flight");

    // at most three transactions in the pipeline
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (flight_reg == 2'd3) |-> !(in_take && !out_take))
        else $error("pipeline overfilled");

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(drive)
            && $stable(saturated) && $stable(target_reached)))
        else $error("held result changed");

endmodule

bind pid_controller_step_core pidc_checker u_pidc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive          (drive),
    .saturated      (saturated),
    .target_reached (target_reached)
);

// File: sim/tb_top.sv
// self-checking testbench for the pid step core: queued stimulus, in-line loop predictor, monitor
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int IDLE_PCT     = 28;
    localparam int PHASE_ITEMS  = 200;
    // extra cycles after the drain to catch any stray result
    localparam int TAIL_CYCLES  = 8;

    // register indexes with no register behind them; writes there must be ignored
    localparam logic [pidc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [pidc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [pidc_pkg::ERR_W-1:0] OVR_MOST_NEG = 17'h10000;
    localparam logic signed [pidc_pkg::ERR_W-1:0] OVR_MOST_POS = 17'h0FFFF;
    localparam logic signed [pidc_pkg::ERR_W-1:0] OVR_MINUS_1  = 17'h1FFFF;
    localparam logic signed [pidc_pkg::ERR_W-1:0] OVR_NONE     = 17'h00000;

    // one input transaction
    typedef struct packed {
        logic                               cmd;
        logic signed [pidc_pkg::DATA_W-1:0] setpoint;
        logic signed [pidc_pkg::DATA_W-1:0] measured;
        logic signed [pidc_pkg::ERR_W-1:0]  error_override;
    } loop_txn_t;

    // one result transaction
    typedef struct packed {
        logic signed [pidc_pkg::DATA_W-1:0] drive;
        logic                               saturated;
        logic                               reached;
    } drive_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;

    logic                                cfg_write = 1'b0;
    logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [pidc_pkg::DATA_W-1:0]         cfg_data = '0;

    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic                                cmd = pidc_pkg::CMD_UPDATE;
    logic signed [pidc_pkg::DATA_W-1:0]  setpoint = '0;
    logic signed [pidc_pkg::DATA_W-1:0]  measured = '0;
    logic signed [pidc_pkg::ERR_W-1:0]   error_override = OVR_NONE;

    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [pidc_pkg::DATA_W-1:0]  drive;
    logic                                saturated;
    logic                                target_reached;

    // transactions waiting to be offered, the one on the bus, and results still owed
    loop_txn_t                           pending_q[$];
    loop_txn_t                           on_bus = '0;
    drive_result_t                       drive_expected_q[$];

    // predictor copy of the configuration, at reset values
    logic signed [pidc_pkg::DATA_W-1:0]  k_p = '0;
    logic signed [pidc_pkg::DATA_W-1:0]  k_i = '0;
    logic signed [pidc_pkg::DATA_W-1:0]  k_d = '0;
    logic signed [pidc_pkg::DATA_W-1:0]  lim_lo = pidc_pkg::DRIVE_MIN_RST;
    logic signed [pidc_pkg::DATA_W-1:0]  lim_hi = pidc_pkg::DRIVE_MAX_RST;
    logic        [pidc_pkg::DATA_W-1:0]  band = '0;

    // predictor copy of the loop state
    logic signed [pidc_pkg::PREV_W-1:0]  prev_err = '0;
    logic signed [pidc_pkg::SUM_W-1:0]   err_sum = '0;

    // steady turns idling off on both sides; near_span sets how close measured sits to setpoint
    logic                                steady = 1'b0;
    int                                  near_span = 64;
    int                                  mismatches = 0;
    int                                  cycle_count = 0;

    pid_controller_step_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .setpoint       (setpoint),
        .measured       (measured),
        .error_override (error_override),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive          (drive),
        .saturated      (saturated),
        .target_reached (target_reached)
    );

    always #CLK_HALF clk = ~clk;

    // one loop step: updates the predictor state and returns the result the core owes
    function automatic drive_result_t predict_drive(loop_txn_t t);
        longint err;
        longint integ;
        longint diff;
        longint acc;
        longint scaled;
        longint mag;
        drive_result_t res;
        res = '0;
        if (t.cmd == pidc_pkg::CMD_CLEAR)
        begin
            prev_err = '0;
            err_sum = '0;
            return res;
        end
        // a nonzero override wins over setpoint minus measured
        err = longint'($signed(t.error_override));
        if (err == 0)
            err = longint'($signed(t.setpoint)) - longint'($signed(t.measured));
        integ = longint'(err_sum) + err;
        if (integ > longint'(pidc_pkg::SUM_MAX))
            integ = longint'(pidc_pkg::SUM_MAX);
        if (integ < longint'(pidc_pkg::SUM_MIN))
            integ = longint'(pidc_pkg::SUM_MIN);
        // anti-windup: a strict sign change of the error dumps the integral
        if ((err > 0 && prev_err < 0) || (err < 0 && prev_err > 0))
            integ = 0;
        diff = err - longint'(prev_err);
        prev_err = err[pidc_pkg::PREV_W-1:0];
        err_sum = integ[pidc_pkg::SUM_W-1:0];
        acc = longint'(k_p) * err + longint'(k_i) * integ + longint'(k_d) * diff;
        // arithmetic shift floors toward minus infinity
        scaled = acc >>> pidc_pkg::FRAC_W;
        // upper limit is tested first, which matters when the limits are crossed
        if (scaled > longint'(lim_hi))
        begin
            scaled = longint'(lim_hi);
            res.saturated = 1'b1;
        end
        else if (scaled < longint'(lim_lo))
        begin
            scaled = longint'(lim_lo);
            res.saturated = 1'b1;
        end
        mag = (err < 0) ? -err : err;
        res.reached = (mag < longint'(band));
        res.drive = scaled[pidc_pkg::DATA_W-1:0];
        return res;
    endfunction

    // mostly random, with the signed extremes and zero turning up often
    function automatic logic [pidc_pkg::DATA_W-1:0] corner16();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return pidc_pkg::DATA_W'($urandom);
        endcase
    endfunction

    function automatic int small_gain();
        return int'($urandom_range(1024)) - 512;
    endfunction

    // random transaction: clears, overrides, errors near the settle band, full-range errors
    function automatic loop_txn_t random_txn();
        loop_txn_t t;
        int pick;
        int delta;
        int meas;
        t = '0;
        t.cmd = pidc_pkg::CMD_UPDATE;
        t.setpoint = corner16();
        t.measured = corner16();
        pick = $urandom_range(99);
        if (pick < 5)
            t.cmd = pidc_pkg::CMD_CLEAR;
        else if (pick < 35)
        begin
            case ($urandom_range(7))
                0: t.error_override = OVR_MOST_NEG;
                1: t.error_override = OVR_MOST_POS;
                2: t.error_override = OVR_MINUS_1;
                default: t.error_override = pidc_pkg::ERR_W'($urandom);
            endcase
        end
        else if (pick < 65)
        begin
            // small errors of either sign: settle band edges and frequent sign flips
            delta = int'($urandom_range(2 * near_span)) - near_span;
            meas = int'($signed(t.setpoint)) - delta;
            if (meas > 32767)
                meas = 32767;
            if (meas < -32768)
                meas = -32768;
            t.measured = meas[pidc_pkg::DATA_W-1:0];
        end
        return t;
    endfunction

    task automatic push_txn(input logic c, input int sp, input int ms, input int ovr);
        loop_txn_t t;
        t.cmd = c;
        t.setpoint = sp[pidc_pkg::DATA_W-1:0];
        t.measured = ms[pidc_pkg::DATA_W-1:0];
        t.error_override = ovr[pidc_pkg::ERR_W-1:0];
        pending_q.push_back(t);
    endtask

    task automatic push_random(input int count);
        repeat (count)
            pending_q.push_back(random_txn());
    endtask

    // sender holds back until every queued transaction has gone and every result is in
    task automatic wait_idle();
        while (pending_q.size() != 0 || in_valid || drive_expected_q.size() != 0)
            @(posedge clk);
    endtask

    // one register write; the predictor copy follows at once since the core is idle
    task automatic write_reg(input logic [pidc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pidc_pkg::DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            pidc_pkg::REG_GAIN_P:      k_p = val;
            pidc_pkg::REG_GAIN_I:      k_i = val;
            pidc_pkg::REG_GAIN_D:      k_d = val;
            pidc_pkg::REG_DRIVE_MIN:   lim_lo = val;
            pidc_pkg::REG_DRIVE_MAX:   lim_hi = val;
            pidc_pkg::REG_SETTLE_BAND: band = val;
            default:                   ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_loop(input int gp, input int gi, input int gd,
                            input int lo, input int hi, input int bnd);
        write_reg(pidc_pkg::REG_GAIN_P, gp[pidc_pkg::DATA_W-1:0]);
        write_reg(pidc_pkg::REG_GAIN_I, gi[pidc_pkg::DATA_W-1:0]);
        write_reg(pidc_pkg::REG_GAIN_D, gd[pidc_pkg::DATA_W-1:0]);
        write_reg(pidc_pkg::REG_DRIVE_MIN, lo[pidc_pkg::DATA_W-1:0]);
        write_reg(pidc_pkg::REG_DRIVE_MAX, hi[pidc_pkg::DATA_W-1:0]);
        write_reg(pidc_pkg::REG_SETTLE_BAND, bnd[pidc_pkg::DATA_W-1:0]);
        end_writes();
    endtask

    // driver: predicts on each accepted transaction, holds while stalled, else offers the next
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                drive_expected_q.push_back(predict_drive(on_bus));
            if (!(in_valid && in_stall))
            begin
                if (pending_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    on_bus = pending_q.pop_front();
                    cmd <= on_bus.cmd;
                    setpoint <= on_bus.setpoint;
                    measured <= on_bus.measured;
                    error_override <= on_bus.error_override;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted result against the oldest expectation, stalls at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_expected_q.size() == 0)
                begin
                    $error("result with no transaction outstanding: drive %0d", drive);
                    mismatches++;
                end
                else
                begin
                    if (drive !== drive_expected_q[0].drive)
                    begin
                        $error("drive: expected %0d, got %0d",
                               drive_expected_q[0].drive, drive);
                        mismatches++;
                    end
                    if (saturated !== drive_expected_q[0].saturated)
                    begin
                        $error("saturated: expected %0b, got %0b",
                               drive_expected_q[0].saturated, saturated);
                        mismatches++;
                    end
                    if (target_reached !== drive_expected_q[0].reached)
                    begin
                        $error("target_reached: expected %0b, got %0b",
                               drive_expected_q[0].reached, target_reached);
                        mismatches++;
                    end
                    void'(drive_expected_q.pop_front());
                end
            end
            out_stall <= steady ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: zero gains give a zero drive, zero band never counts as reached
        push_txn(pidc_pkg::CMD_UPDATE, 32767, -32768, 0);
        push_txn(pidc_pkg::CMD_UPDATE, 0, 0, 0);
        wait_idle();

        // directed transactions on a moderate loop
        set_loop(256, 16, 64, -1000, 1000, 50);
        push_txn(pidc_pkg::CMD_CLEAR, 1234, -1234, 77);
        push_txn(pidc_pkg::CMD_UPDATE, 32767, -32768, 0);
        // sign change against the last error dumps the integral
        push_txn(pidc_pkg::CMD_UPDATE, -32768, 32767, 0);
        push_txn(pidc_pkg::CMD_UPDATE, 0, 0, int'(OVR_MOST_NEG) - 131072);
        push_txn(pidc_pkg::CMD_UPDATE, 0, 0, 65535);
        // override wins over a full-scale setpoint difference
        push_txn(pidc_pkg::CMD_UPDATE, -32768, 32767, 1);
        push_txn(pidc_pkg::CMD_UPDATE, 32767, -32768, -1);
        push_txn(pidc_pkg::CMD_UPDATE, 0, 0, 0);
        // either side of the settle band edge
        push_txn(pidc_pkg::CMD_UPDATE, 100, 51, 0);
        push_txn(pidc_pkg::CMD_UPDATE, 100, 50, 0);
        push_txn(pidc_pkg::CMD_UPDATE, -50, 0, 0);
        push_txn(pidc_pkg::CMD_UPDATE, -49, 0, 0);
        push_txn(pidc_pkg::CMD_CLEAR, 0, 0, 0);
        // integral builds up while the upper clamp holds, then negative errors hit the lower one
        push_txn(pidc_pkg::CMD_UPDATE, 1000, 0, 0);
        push_txn(pidc_pkg::CMD_UPDATE, 1000, 0, 0);
        push_txn(pidc_pkg::CMD_UPDATE, 1000, 0, 0);
        push_txn(pidc_pkg::CMD_UPDATE, -1000, 0, 0);
        push_txn(pidc_pkg::CMD_UPDATE, -1000, 0, 0);
        push_txn(pidc_pkg::CMD_CLEAR, -1, -1, -1);
        push_txn(pidc_pkg::CMD_UPDATE, -32768, -32768, 0);
        wait_idle();

        // random phase on small gains and a wide band
        near_span = 400;
        set_loop(small_gain(), small_gain(), small_gain(), -2000, 2000, 300);
        push_random(PHASE_ITEMS);
        wait_idle();

        // back-to-back phase: no idling on either side, full-range gains
        steady = 1'b1;
        near_span = 64;
        set_loop($urandom, $urandom, $urandom, -int'($urandom_range(32768)),
                 int'($urandom_range(32767)), $urandom_range(65535));
        push_random(PHASE_ITEMS);
        wait_idle();
        steady = 1'b0;

        // crossed limits: the upper limit is tested first
        near_span = 200;
        set_loop(small_gain(), small_gain(), small_gain(), 500, -500, 0);
        push_random(PHASE_ITEMS);
        wait_idle();

        // register extremes, then writes to unused indexes that must change nothing
        near_span = 2000;
        set_loop(32767, -32768, 32767, -32768, 32767, 65535);
        write_reg(REG_SPARE_LO, 16'h0000);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        end_writes();
        push_random(PHASE_ITEMS / 2);
        wait_idle();
        set_loop(-32768, 32767, -32768, -32768, 32767, 1);
        push_random(PHASE_ITEMS / 2);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: pid_controller_step_core.f
sv/pidc_pkg.sv
sv/pidc_cfg_regs.sv
sv/pidc_drive_calc.sv
sv/pid_controller_step_core.sv
sv/pidc_checker.sv
sim/tb_top.sv
